@@ src/tsi_pkg.sv @@
// shared widths, codes and types for the timestamp sync interpolator
`timescale 1ns / 1ps
package tsi_pkg;
  localparam int TIME_W = 48;
  localparam int LAT_W = 31;
  localparam int LON_W = 32;
  localparam int ALT_W = 28;
  localparam int GAP_W = 24;
  localparam int SPAN_W = GAP_W + 1;
  localparam int STATUS_W = 2;
  localparam int DEFAULT_DEPTH = 16;
  localparam logic [GAP_W-1:0] GAP_RESET = 24'd200000;
  // widest coordinate: every lane runs at this width so all finish together
  localparam int LANE_W = LON_W;

  localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SHORT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EARLY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_GAP = 2'd3;

  localparam logic KIND_PUSH = 1'b0;

  typedef struct packed {
    logic [TIME_W-1:0] stamp;
    logic signed [LAT_W-1:0] lat;
    logic signed [LON_W-1:0] lon;
    logic signed [ALT_W-1:0] alt;
  } entry_t;
endpackage

@@ src/tsi_lane.sv @@
// bit-serial multiply then restoring divide for one interpolated coordinate
`timescale 1ns / 1ps
module tsi_lane #(
  parameter int W = tsi_pkg::LAT_W
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          go,
  input  logic [tsi_pkg::SPAN_W-1:0]    a,
  input  logic [tsi_pkg::SPAN_W-1:0]    d,
  input  logic signed [W-1:0]           v0,
  input  logic signed [W-1:0]           v1,
  output logic signed [W-1:0]           res,
  output logic                          done
);
  localparam int SW = tsi_pkg::SPAN_W;
  localparam int MAG_W = tsi_pkg::LANE_W + 1;
  localparam int PROD_W = MAG_W + SW;
  localparam int NUM_W = PROD_W + 1;
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic run, mul;
  logic [CNT_W-1:0] cnt;
  logic [MAG_W-1:0] mag;
  logic neg;
  logic signed [W-1:0] base;
  logic [SW-1:0] abits;
  logic [SW-1:0] dreg;
  logic [PROD_W-1:0] acc;
  logic [NUM_W-1:0] num;
  logic [SW:0] rem;
  logic [MAG_W-1:0] q;

  logic signed [MAG_W-1:0] diff;
  logic [PROD_W-1:0] acc_next;
  logic [SW+1:0] trial;
  logic ge;
  logic [MAG_W-1:0] q_next;
  logic [MAG_W-1:0] sum;

  always_comb begin
    diff = MAG_W'(v1) - MAG_W'(v0);
    acc_next = {acc[PROD_W-2:0], 1'b0} + (abits[SW-1] ? PROD_W'(mag) : '0);
    trial = {rem, num[NUM_W-1]};
    ge = trial >= {1'b0, dreg, 1'b0};
    q_next = {q[MAG_W-2:0], ge};
    sum = neg ? (MAG_W'(base) - q_next) : (MAG_W'(base) + q_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      mul <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        mul <= 1'b1;
        cnt <= CNT_W'(SW);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (mul) begin
          if (cnt == CNT_W'(1)) begin
            mul <= 1'b0;
            cnt <= CNT_W'(NUM_W);
          end
        end else if (cnt == CNT_W'(1)) begin
          run <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (go) begin
      neg <= diff[MAG_W-1];
      mag <= diff[MAG_W-1] ? (MAG_W'(0) - diff) : diff;
      base <= v0;
      abits <= a;
      dreg <= d;
      acc <= '0;
    end else if (run) begin
      if (mul) begin
        abits <= {abits[SW-2:0], 1'b0};
        acc <= acc_next;
        if (cnt == CNT_W'(1)) begin
          // numerator 2*prod + d so the divide by 2*d rounds half away
          num <= {acc_next, 1'b0} + NUM_W'(dreg);
          rem <= '0;
          q <= '0;
        end
      end else begin
        num <= {num[NUM_W-2:0], 1'b0};
        rem <= ge ? (SW+1)'(trial - {1'b0, dreg, 1'b0}) : trial[SW:0];
        q <= q_next;
        if (cnt == CNT_W'(1)) res <= sum[W-1:0];
      end
    end
  end
endmodule

@@ src/timestamp_sync_interpolator.sv @@
// top level: sample ring, sync sequencer and three interpolation lanes
//  channel | handshake              | word
//  input   | start, busy            | kind, stamp, lat_in, lon_in, alt_in
//  result  | done (one-cycle pulse) | status, stamp_out, lat_out, lon_out, alt_out
//  config  | cfg_valid, cfg_ready   | cfg_data (max_gap)
// a push is written into the ring from idle, and a sync with fewer than two samples is answered at once;
// otherwise each sample pair examined passes through two registered reads and a check,
// and an interpolation adds a multiply, a divide and a hand-off in the lanes;
// each dropped sample adds another read-and-check pass; the result word is registered, out the cycle after.
// synchronous reset empties the ring; stored samples are not cleared.
// the receiver cannot stall: done marks each result for one cycle only.
`timescale 1ns / 1ps
module timestamp_sync_interpolator #(
  parameter int QUEUE_DEPTH = tsi_pkg::DEFAULT_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              kind,
  input  logic [tsi_pkg::TIME_W-1:0]        stamp,
  input  logic signed [tsi_pkg::LAT_W-1:0]  lat_in,
  input  logic signed [tsi_pkg::LON_W-1:0]  lon_in,
  input  logic signed [tsi_pkg::ALT_W-1:0]  alt_in,
  output logic                              done,
  output logic [tsi_pkg::STATUS_W-1:0]      status,
  output logic [tsi_pkg::TIME_W-1:0]        stamp_out,
  output logic signed [tsi_pkg::LAT_W-1:0]  lat_out,
  output logic signed [tsi_pkg::LON_W-1:0]  lon_out,
  output logic signed [tsi_pkg::ALT_W-1:0]  alt_out,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tsi_pkg::GAP_W-1:0]         cfg_data
);
  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int TW = tsi_pkg::TIME_W;
  localparam int SW = tsi_pkg::SPAN_W;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD0  = 5'b00010,
    S_RD1  = 5'b00100,
    S_CHK  = 5'b01000,
    S_DIV  = 5'b10000
  } state_t;

  state_t state, state_next;
  logic [IDX_W-1:0] head, head_next, head_inc, wslot, raddr;
  logic [CNT_W-1:0] fill, fill_next;
  logic [IDX_W:0] slot_sum;
  logic [tsi_pkg::GAP_W-1:0] max_gap;
  logic [TW-1:0] target;
  tsi_pkg::entry_t ring [QUEUE_DEPTH];
  tsi_pkg::entry_t rdata, e0, wdata;
  logic we;

  logic emit, go;
  logic [tsi_pkg::STATUS_W-1:0] emit_status;
  logic emit_vals, emit_front;
  logic [TW-1:0] t0, t1, a_full, b_full, span_full;
  logic gap_bad;
  logic signed [tsi_pkg::LAT_W-1:0] lat_res;
  logic signed [tsi_pkg::LON_W-1:0] lon_res;
  logic signed [tsi_pkg::ALT_W-1:0] alt_res;
  logic lat_done, lon_done, alt_done;

  assign busy = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign head_inc = (head == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
  assign slot_sum = (IDX_W + 1)'(head) + (IDX_W + 1)'(fill);
  assign raddr = (state == S_RD0) ? head : head_inc;
  assign wdata = '{stamp: stamp, lat: lat_in, lon: lon_in, alt: alt_in};

  always_comb begin
    t0 = e0.stamp;
    t1 = rdata.stamp;
    a_full = target - t0;
    b_full = t1 - target;
    span_full = t1 - t0;
    gap_bad = (a_full > TW'(max_gap)) || (b_full > TW'(max_gap));
    if (fill == CNT_W'(QUEUE_DEPTH)) begin
      wslot = head;
    end else if (slot_sum >= (IDX_W + 1)'(QUEUE_DEPTH)) begin
      wslot = IDX_W'(slot_sum - (IDX_W + 1)'(QUEUE_DEPTH));
    end else begin
      wslot = slot_sum[IDX_W-1:0];
    end
  end

  always_comb begin
    state_next = state;
    head_next = head;
    fill_next = fill;
    we = 1'b0;
    emit = 1'b0;
    emit_status = tsi_pkg::ST_OK;
    emit_vals = 1'b0;
    emit_front = 1'b0;
    go = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (kind == tsi_pkg::KIND_PUSH) begin
            we = 1'b1;
            if (fill == CNT_W'(QUEUE_DEPTH)) head_next = head_inc;
            else fill_next = fill + 1'b1;
          end else if (fill < CNT_W'(2)) begin
            emit = 1'b1;
            emit_status = tsi_pkg::ST_SHORT;
          end else begin
            state_next = S_RD0;
          end
        end
      end
      S_RD0: state_next = S_RD1;
      S_RD1: state_next = S_CHK;
      S_CHK: begin
        state_next = S_IDLE;
        if (t0 > target) begin
          emit = 1'b1;
          emit_status = tsi_pkg::ST_EARLY;
        end else if (t1 < target) begin
          head_next = head_inc;
          fill_next = fill - 1'b1;
          if (fill < CNT_W'(3)) begin
            emit = 1'b1;
            emit_status = tsi_pkg::ST_SHORT;
          end else begin
            state_next = S_RD0;
          end
        end else if (gap_bad) begin
          head_next = head_inc;
          fill_next = fill - 1'b1;
          emit = 1'b1;
          emit_status = tsi_pkg::ST_GAP;
        end else if (t1 == t0) begin
          emit = 1'b1;
          emit_front = 1'b1;
        end else begin
          go = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (lat_done) begin
          emit = 1'b1;
          emit_vals = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // sample ring
  always_ff @(posedge clk) begin
    if (we) ring[wslot] <= wdata;
    rdata <= ring[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head <= '0;
      fill <= '0;
      max_gap <= tsi_pkg::GAP_RESET;
      done <= 1'b0;
    end else begin
      state <= state_next;
      head <= head_next;
      fill <= fill_next;
      done <= emit;
      if (cfg_valid && cfg_ready) max_gap <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) target <= stamp;
    if (state == S_RD1) e0 <= rdata;
    if (emit) begin
      status <= emit_status;
      stamp_out <= (state == S_IDLE) ? stamp : target;
      if (emit_front) begin
        lat_out <= e0.lat;
        lon_out <= e0.lon;
        alt_out <= e0.alt;
      end else if (emit_vals) begin
        lat_out <= lat_res;
        lon_out <= lon_res;
        alt_out <= alt_res;
      end else begin
        lat_out <= '0;
        lon_out <= '0;
        alt_out <= '0;
      end
    end
  end

  tsi_lane #(.W(tsi_pkg::LAT_W)) u_lat (
    .clk(clk), .rst(rst), .go(go), .a(SW'(a_full[tsi_pkg::GAP_W-1:0])),
    .d(span_full[SW-1:0]), .v0(e0.lat), .v1(rdata.lat), .res(lat_res), .done(lat_done)
  );
  tsi_lane #(.W(tsi_pkg::LON_W)) u_lon (
    .clk(clk), .rst(rst), .go(go), .a(SW'(a_full[tsi_pkg::GAP_W-1:0])),
    .d(span_full[SW-1:0]), .v0(e0.lon), .v1(rdata.lon), .res(lon_res), .done(lon_done)
  );
  tsi_lane #(.W(tsi_pkg::ALT_W)) u_alt (
    .clk(clk), .rst(rst), .go(go), .a(SW'(a_full[tsi_pkg::GAP_W-1:0])),
    .d(span_full[SW-1:0]), .v0(e0.alt), .v1(rdata.alt), .res(alt_res), .done(alt_done)
  );

  // a push into a full ring keeps it full
  a_full_push: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && kind == tsi_pkg::KIND_PUSH && fill == CNT_W'(QUEUE_DEPTH))
    |=> (fill == CNT_W'(QUEUE_DEPTH)))
    else $error("ring fill changed on push into full ring");

  // an accepted sync either answers at once or starts the scan
  a_sync_moves: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && kind != tsi_pkg::KIND_PUSH) |=> (busy || done))
    else $error("sync word accepted but neither answered nor started");

  // lanes finish together and only while the sequencer waits for them
  a_lane_done: assert property (@(posedge clk) disable iff (rst)
    (lat_done || lon_done || alt_done) |->
    (lat_done && lon_done && alt_done && state == S_DIV))
    else $error("interpolation lanes out of step");
endmodule

@@ tb/sv/tb_timestamp_sync_interpolator.sv @@
// testbench for the timestamp sync interpolator: directed table, then random pushes and syncs
`timescale 1ns / 1ps
module tb_timestamp_sync_interpolator;
  localparam int TIME_W = tsi_pkg::TIME_W;
  localparam int LAT_W = tsi_pkg::LAT_W;
  localparam int LON_W = tsi_pkg::LON_W;
  localparam int ALT_W = tsi_pkg::ALT_W;
  localparam int GAP_W = tsi_pkg::GAP_W;
  localparam int STATUS_W = tsi_pkg::STATUS_W;
  localparam int DEPTH = tsi_pkg::DEFAULT_DEPTH;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int FIX_SLOTS = 64;
  localparam int ROW_SLOTS = 64;
  localparam logic KIND_SYNC = 1'b1;
  localparam logic [TIME_W-1:0] T_MAX = {TIME_W{1'b1}};

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [TIME_W-1:0] stamp;
    logic signed [LAT_W-1:0] lat;
    logic signed [LON_W-1:0] lon;
    logic signed [ALT_W-1:0] alt;
  } fix_t;

  typedef struct {
    logic kind;
    logic [TIME_W-1:0] stamp;
    longint lat, lon, alt;
    bit typed;
    logic [STATUS_W-1:0] status;
    longint lat_o, lon_o, alt_o;
  } row_t;

  logic clk = 1'b0, rst = 1'b1;
  logic start = 1'b0, kind = tsi_pkg::KIND_PUSH;
  logic [TIME_W-1:0] stamp = '0;
  logic signed [LAT_W-1:0] lat_in = '0;
  logic signed [LON_W-1:0] lon_in = '0;
  logic signed [ALT_W-1:0] alt_in = '0;
  logic cfg_valid = 1'b0;
  logic [GAP_W-1:0] cfg_data = '0;
  logic busy, done, cfg_ready;
  logic [STATUS_W-1:0] status;
  logic [TIME_W-1:0] stamp_out;
  logic signed [LAT_W-1:0] lat_out;
  logic signed [LON_W-1:0] lon_out;
  logic signed [ALT_W-1:0] alt_out;

  timestamp_sync_interpolator dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // shadow of the sample ring
  logic [TIME_W-1:0] ring_t [DEPTH];
  longint ring_lat [DEPTH], ring_lon [DEPTH], ring_alt [DEPTH];
  int head, fill;
  logic [GAP_W-1:0] gap_lim;
  // expected result words, in order
  fix_t fix_buf [FIX_SLOTS];
  int fix_wr = 0;
  int fix_rd = 0;
  // directed stimulus table
  row_t rows [ROW_SLOTS];
  int n_rows = 0;
  int errors = 0;
  int cycles = 0;
  int idle_pct = 0;

  function automatic longint lerp(longint v0, longint v1, longint unsigned a,
                                  longint unsigned d);
    longint diff;
    longint unsigned mag, q;
    diff = v1 - v0;
    mag = (diff < 0) ? longint'(-diff) : diff;
    q = (2 * mag * a + d) / (2 * d);
    return (diff < 0) ? v0 - longint'(q) : v0 + longint'(q);
  endfunction

  task automatic drop_oldest();
    head = (head + 1) % DEPTH;
    fill--;
  endtask

  task automatic add_fix(input fix_t f);
    fix_buf[fix_wr % FIX_SLOTS] = f;
    fix_wr++;
  endtask

  task automatic add_row(input row_t r);
    rows[n_rows] = r;
    n_rows++;
  endtask

  // updates the shadow ring and returns the fix a sync should produce
  task automatic predict_item(input row_t r, output bit has_fix, output fix_t f);
    int s0, s1;
    logic [TIME_W-1:0] t0, t1;
    has_fix = 1'b0;
    f = '{tsi_pkg::ST_OK, r.stamp, 0, 0, 0};
    if (r.kind == tsi_pkg::KIND_PUSH) begin
      if (fill >= DEPTH) drop_oldest();
      s0 = (head + fill) % DEPTH;
      ring_t[s0] = r.stamp;
      ring_lat[s0] = longint'(signed'(LAT_W'(r.lat)));
      ring_lon[s0] = longint'(signed'(LON_W'(r.lon)));
      ring_alt[s0] = longint'(signed'(ALT_W'(r.alt)));
      fill++;
      return;
    end
    has_fix = 1'b1;
    while (fill >= 2) begin
      t0 = ring_t[head];
      t1 = ring_t[(head + 1) % DEPTH];
      if (t0 > r.stamp) begin
        f.status = tsi_pkg::ST_EARLY;
        return;
      end
      if (t1 < r.stamp) begin
        drop_oldest();
        continue;
      end
      if (r.stamp - t0 > gap_lim || t1 - r.stamp > gap_lim) begin
        drop_oldest();
        f.status = tsi_pkg::ST_GAP;
        return;
      end
      break;
    end
    if (fill < 2) begin
      f.status = tsi_pkg::ST_SHORT;
      return;
    end
    s0 = head;
    s1 = (head + 1) % DEPTH;
    t0 = ring_t[s0];
    t1 = ring_t[s1];
    if (t0 == t1) begin
      f.lat = LAT_W'(ring_lat[s0]);
      f.lon = LON_W'(ring_lon[s0]);
      f.alt = ALT_W'(ring_alt[s0]);
    end else begin
      f.lat = LAT_W'(lerp(ring_lat[s0], ring_lat[s1], r.stamp - t0, t1 - t0));
      f.lon = LON_W'(lerp(ring_lon[s0], ring_lon[s1], r.stamp - t0, t1 - t0));
      f.alt = ALT_W'(lerp(ring_alt[s0], ring_alt[s1], r.stamp - t0, t1 - t0));
    end
  endtask

  task automatic send_word(input row_t r);
    bit has_fix;
    fix_t f;
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    kind <= r.kind;
    stamp <= r.stamp;
    lat_in <= LAT_W'(r.lat);
    lon_in <= LON_W'(r.lon);
    alt_in <= ALT_W'(r.alt);
    do @(posedge clk); while (busy);
    predict_item(r, has_fix, f);
    if (r.typed)
      f = '{r.status, r.stamp, LAT_W'(r.lat_o), LON_W'(r.lon_o), ALT_W'(r.alt_o)};
    if (has_fix) add_fix(f);
  endtask

  task automatic write_gap(input logic [GAP_W-1:0] value);
    start <= 1'b0;
    wait (fix_rd == fix_wr);
    repeat (200) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    gap_lim = value;
  endtask

  function automatic row_t plain(logic k, logic [TIME_W-1:0] t, longint la, longint lo,
                                 longint al);
    return '{k, t, la, lo, al, 1'b0, tsi_pkg::ST_OK, 0, 0, 0};
  endfunction

  function automatic row_t fixed(logic [TIME_W-1:0] t, logic [STATUS_W-1:0] s, longint la,
                                 longint lo, longint al);
    return '{KIND_SYNC, t, 0, 0, 0, 1'b1, s, la, lo, al};
  endfunction

  function automatic longint rand_val(int w, longint lo, longint hi);
    if ($urandom_range(1)) return longint'({$urandom, $urandom}) >>> (64 - w);
    return lo + longint'({$urandom, $urandom} % longint'(hi - lo + 1));
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
    if (!rst && done) begin
      if (fix_rd == fix_wr) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        fix_t e;
        e = fix_buf[fix_rd % FIX_SLOTS];
        fix_rd++;
        if (status !== e.status) begin
          $error("status exp %0d got %0d", e.status, status); errors++;
        end
        if (stamp_out !== e.stamp) begin
          $error("stamp_out exp %0d got %0d", e.stamp, stamp_out); errors++;
        end
        if (lat_out !== e.lat) begin
          $error("lat_out exp %0d got %0d", e.lat, lat_out); errors++;
        end
        if (lon_out !== e.lon) begin
          $error("lon_out exp %0d got %0d", e.lon, lon_out); errors++;
        end
        if (alt_out !== e.alt) begin
          $error("alt_out exp %0d got %0d", e.alt, alt_out); errors++;
        end
      end
    end
  end

  initial begin
    row_t r;
    logic [GAP_W-1:0] gaps [4] = '{24'hFFFFFF, 24'd0, 24'd3000, tsi_pkg::GAP_RESET};
    int pcts [4] = '{35, 51, 0, 0};
    longint unsigned now, span;
    head = 0;
    fill = 0;
    gap_lim = tsi_pkg::GAP_RESET;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    add_row(fixed(0, tsi_pkg::ST_SHORT, 0, 0, 0));
    add_row(plain(tsi_pkg::KIND_PUSH, 100, 900000000, -1800000000, -1000000));
    add_row(fixed(100, tsi_pkg::ST_SHORT, 0, 0, 0));
    // equal neighbour times give the front sample
    add_row(plain(tsi_pkg::KIND_PUSH, 100, -900000000, 1800000000, 100000000));
    add_row(fixed(100, tsi_pkg::ST_OK, 900000000, -1800000000, -1000000));
    add_row(fixed(50, tsi_pkg::ST_EARLY, 0, 0, 0));
    add_row(plain(tsi_pkg::KIND_PUSH, 300, 0, 0, 0));
    add_row(plain(KIND_SYNC, 200, 0, 0, 0));
    add_row(plain(tsi_pkg::KIND_PUSH, 500000, 7, -7, 7));
    add_row(plain(KIND_SYNC, 300, 0, 0, 0));
    add_row(fixed(400, tsi_pkg::ST_GAP, 0, 0, 0));
    add_row(plain(tsi_pkg::KIND_PUSH, T_MAX, -1, -1, -1));
    add_row(fixed(T_MAX, tsi_pkg::ST_GAP, 0, 0, 0));
    add_row(plain(tsi_pkg::KIND_PUSH, 0, 0, 0, 0));
    add_row(fixed(T_MAX, tsi_pkg::ST_SHORT, 0, 0, 0));
    add_row(plain(tsi_pkg::KIND_PUSH, 2, 1, -1, 3));
    // halfway ties round away from zero
    add_row(fixed(1, tsi_pkg::ST_OK, 1, -1, 2));
    for (int i = 0; i < 18; i++)
      add_row(plain(tsi_pkg::KIND_PUSH, TIME_W'(1000 + i),
                    rand_val(LAT_W, -900000000, 900000000),
                    rand_val(LON_W, -1800000000, 1800000000),
                    rand_val(ALT_W, -1000000, 100000000)));
    add_row(plain(KIND_SYNC, 1010, 0, 0, 0));
    for (int i = 0; i < n_rows; i++) send_word(rows[i]);

    now = 2000;
    for (int p = 0; p < 4; p++) begin
      write_gap(gaps[p]);
      idle_pct = pcts[p];
      span = (gaps[p] == 0) ? 4 : gaps[p];
      for (int n = 0; n < 275; n++) begin
        if ($urandom_range(9) == 0) begin
          r = plain(logic'($urandom_range(1)), TIME_W'({$urandom, $urandom}),
                    $urandom, $urandom, $urandom);
        end else if ($urandom_range(9) < 6) begin
          if ($urandom_range(7) != 0)
            now += ($urandom_range(9) == 0) ? 2 * span + $urandom_range(1, 100)
                                            : $urandom_range(1, int'(span));
          r = plain(tsi_pkg::KIND_PUSH, TIME_W'(now),
                    rand_val(LAT_W, -900000000, 900000000),
                    rand_val(LON_W, -1800000000, 1800000000),
                    rand_val(ALT_W, -1000000, 100000000));
        end else begin
          r = plain(KIND_SYNC,
                    TIME_W'(($urandom_range(5) == 0) ? now
                            : now - longint'($urandom_range(0, int'(3 * span)))),
                    0, 0, 0);
        end
        send_word(r);
      end
    end
    start <= 1'b0;
    wait (fix_rd == fix_wr);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule
